@@ rtl/core/icr_pkg.sv @@
`default_nettype none
package icr_pkg;

  localparam int ValW  = 64;
  localparam int RootW = 22;
  localparam int XW    = 32;
  localparam int DenW  = 64;

  typedef logic [ValW-1:0]  val_t;
  typedef logic [RootW-1:0] root_t;
  typedef logic [XW-1:0]    x_t;
  typedef logic [DenW-1:0]  den_t;

  // Work carried down the divider cell chain.
  typedef struct packed {
    logic  vld;
    logic  lut_only;
    root_t small_root;
    x_t    x;
    den_t  den;
    val_t  rem;
    val_t  quo;
  } icr_work_t;

  function automatic logic [7:0] seed_lut(input logic [5:0] idx);
    logic [7:0] r;
    case (idx)
      6'd0: r = 8'd0;     6'd1: r = 8'd54;    6'd2: r = 8'd54;    6'd3: r = 8'd54;
      6'd4: r = 8'd118;   6'd5: r = 8'd118;   6'd6: r = 8'd118;   6'd7: r = 8'd118;
      6'd8: r = 8'd123;   6'd9: r = 8'd129;   6'd10: r = 8'd134;  6'd11: r = 8'd138;
      6'd12: r = 8'd143;  6'd13: r = 8'd147;  6'd14: r = 8'd151;  6'd15: r = 8'd156;
      6'd16: r = 8'd157;  6'd17: r = 8'd161;  6'd18: r = 8'd164;  6'd19: r = 8'd168;
      6'd20: r = 8'd170;  6'd21: r = 8'd173;  6'd22: r = 8'd176;  6'd23: r = 8'd179;
      6'd24: r = 8'd181;  6'd25: r = 8'd185;  6'd26: r = 8'd187;  6'd27: r = 8'd190;
      6'd28: r = 8'd192;  6'd29: r = 8'd194;  6'd30: r = 8'd197;  6'd31: r = 8'd199;
      6'd32: r = 8'd200;  6'd33: r = 8'd202;  6'd34: r = 8'd204;  6'd35: r = 8'd206;
      6'd36: r = 8'd209;  6'd37: r = 8'd211;  6'd38: r = 8'd213;  6'd39: r = 8'd215;
      6'd40: r = 8'd217;  6'd41: r = 8'd219;  6'd42: r = 8'd221;  6'd43: r = 8'd222;
      6'd44: r = 8'd224;  6'd45: r = 8'd225;  6'd46: r = 8'd227;  6'd47: r = 8'd229;
      6'd48: r = 8'd231;  6'd49: r = 8'd232;  6'd50: r = 8'd234;  6'd51: r = 8'd236;
      6'd52: r = 8'd237;  6'd53: r = 8'd239;  6'd54: r = 8'd240;  6'd55: r = 8'd242;
      6'd56: r = 8'd244;  6'd57: r = 8'd245;  6'd58: r = 8'd246;  6'd59: r = 8'd248;
      6'd60: r = 8'd250;  6'd61: r = 8'd251;  6'd62: r = 8'd252;  6'd63: r = 8'd254;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/integer_cube_root_unit.sv @@
`default_nettype none
// Approximate 64-bit integer cube root (table seed plus one Newton step).
// Fully pipelined: one item per cycle. From acceptance to out_tvalid an item
// passes 2 seed stages, a chain of 64 divider cells, one multiply stage and
// one output register. The quotient divider chain sets the latency. A stall
// on out_tready freezes the whole pipeline.
module integer_cube_root_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] value
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata   // [21:0] root
);
  import icr_pkg::*;

  logic      en;
  icr_work_t chain [0:ValW];
  x_t        sum;
  logic      m_vld_r, m_small_r;
  root_t     m_sroot_r;
  x_t        m_prod_r;
  logic      o_vld_r;
  root_t     o_root_r;

  assign en        = !o_vld_r || out_tready;
  assign in_tready = en;

  icr_seed u_seed (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_tvalid && in_tready), .in_val(in_tdata), .out_work(chain[0])
  );

  for (genvar g = 0; g < ValW; g++) begin : g_div
    icr_div_cell #(.Bit(ValW - 1 - g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_work(chain[g]), .out_work(chain[g+1])
    );
  end

  assign sum = (chain[ValW].den == '0) ? 32'hFFFF_FFFE + {chain[ValW].x[30:0], 1'b0} + 32'd1
                                       : {chain[ValW].x[30:0], 1'b0} + chain[ValW].quo[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= chain[ValW].vld;
      o_vld_r <= m_vld_r;
    end
    if (en) begin
      m_small_r <= chain[ValW].lut_only;
      m_sroot_r <= chain[ValW].small_root;
      m_prod_r  <= x_t'(sum * 32'd341);
      o_root_r  <= m_small_r ? m_sroot_r : root_t'(m_prod_r >> 10);
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {2'b00, o_root_r};

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:22] == 2'b00)
    else $error("pad bits set");
endmodule
`default_nettype wire

@@ rtl/core/icr_seed.sv @@
`default_nettype none
// Seed stage: top bit index, table lookup, x*(x-1). Two register levels.
module icr_seed (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire icr_pkg::val_t     in_val,
  output icr_pkg::icr_work_t     out_work
);
  import icr_pkg::*;

  logic [6:0]  nbits;
  logic [4:0]  b2;
  logic [5:0]  sh;
  logic [5:0]  idx;
  logic [14:0] prod;
  logic [39:0] seed_sh;
  logic        lut_only;
  logic [8:0]  small_sum;

  logic  s1_vld_r, s1_small_r;
  root_t s1_sroot_r;
  x_t    s1_x_r;
  val_t  s1_val_r;
  icr_work_t w_r;

  always_comb begin
    nbits = '0;
    for (int i = 0; i < ValW; i++) begin
      if (in_val[i]) nbits = 7'(i + 1);
    end
    prod  = 15'(nbits) * 15'd84;
    b2    = 5'((prod >> 8) - 15'd1);
    sh    = 6'(b2 * 6'd3);
    idx   = 6'(in_val >> sh);
    seed_sh = 40'({1'b0, seed_lut(idx)} + 9'd10) << b2;
    lut_only = (nbits < 7'd7);
    small_sum = {1'b0, seed_lut(in_val[5:0])} + 9'd35;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      w_r.vld  <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      w_r.vld  <= s1_vld_r;
    end
    if (en) begin
      s1_small_r <= lut_only;
      s1_sroot_r <= root_t'(small_sum >> 6);
      s1_x_r     <= x_t'(seed_sh[31:0] >> 6);
      s1_val_r   <= in_val;
      w_r.lut_only   <= s1_small_r;
      w_r.small_root <= s1_sroot_r;
      w_r.x          <= s1_x_r;
      w_r.den        <= 64'(s1_x_r) * 64'(s1_x_r - 32'd1);
      w_r.rem        <= s1_val_r;
      w_r.quo        <= '0;
    end
  end

  assign out_work = w_r;
endmodule
`default_nettype wire

@@ rtl/core/icr_div_cell.sv @@
`default_nettype none
// One restoring-division cell: resolves quotient bit Bit.
module icr_div_cell #(
  parameter int Bit = 63
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire icr_pkg::icr_work_t in_work,
  output icr_pkg::icr_work_t  out_work
);
  import icr_pkg::*;

  logic [127:0] dsh;
  logic         fits;
  icr_work_t    nxt, w_r;

  always_comb begin
    dsh  = {64'd0, in_work.den} << Bit;
    fits = ({64'd0, in_work.rem} >= dsh);
    nxt  = in_work;
    if (fits) begin
      nxt.rem      = in_work.rem - dsh[63:0];
      nxt.quo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) w_r.vld <= 1'b0;
    else if (en) w_r.vld <= nxt.vld;
    if (en) begin
      w_r.lut_only   <= nxt.lut_only;
      w_r.small_root <= nxt.small_root;
      w_r.x          <= nxt.x;
      w_r.den        <= nxt.den;
      w_r.rem        <= nxt.rem;
      w_r.quo        <= nxt.quo;
    end
  end

  assign out_work = w_r;
endmodule
`default_nettype wire

@@ verif/integer_cube_root_unit_test.sv @@
module integer_cube_root_unit_test;
  import icr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  logic [7:0] cbrt_tab [64] = '{
      0,  54,  54,  54, 118, 118, 118, 118,
    123, 129, 134, 138, 143, 147, 151, 156,
    157, 161, 164, 168, 170, 173, 176, 179,
    181, 185, 187, 190, 192, 194, 197, 199,
    200, 202, 204, 206, 209, 211, 213, 215,
    217, 219, 221, 222, 224, 225, 227, 229,
    231, 232, 234, 236, 237, 239, 240, 242,
    244, 245, 246, 248, 250, 251, 252, 254};

  root_t  roots_due [$];
  int     errors = 0;
  int     sent = 0;
  int     checked = 0;
  int     stall_left = 0;
  bit     calm = 1'b0;

  integer_cube_root_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  function automatic root_t approx_cbrt(input logic [63:0] v);
    int unsigned b;
    int unsigned sh;
    logic [5:0]  idx;
    logic [63:0] seed;
    logic [31:0] x;
    logic [31:0] xm1;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] t;
    b = 0;
    for (int i = 0; i < 64; i++) if (v[i]) b = i + 1;
    if (b < 7) return root_t'((32'(cbrt_tab[v[5:0]]) + 32'd35) >> 6);
    b = ((b * 84) >> 8) - 1;
    sh = (b * 3) & 63;
    idx = 6'(v >> sh);
    seed = (64'(cbrt_tab[idx]) + 64'd10) << (b & 31);
    x = seed[31:0] >> 6;
    xm1 = x - 32'd1;
    den = 64'(x) * 64'(xm1);
    quo = (den != 0) ? v / den : '1;
    t = 64'(x) * 64'd2 + {32'd0, quo[31:0]};
    x = t[31:0];
    t = 64'(x) * 64'd341;
    return root_t'(t[31:0] >> 10);
  endfunction

  task automatic send_value(input logic [63:0] v);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    roots_due.push_back(approx_cbrt(v));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (roots_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (roots_due.size() == 0) begin
        $display("%0t: unexpected root, expected none, actual %0d", $time, out_tdata[21:0]);
        errors++;
      end else begin
        if (out_tdata[21:0] !== roots_due[0]) begin
          $display("%0t: root mismatch, expected %0d, actual %0d",
                   $time, roots_due[0], out_tdata[21:0]);
          errors++;
        end
        void'(roots_due.pop_front());
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (calm) stall_left = 0;
    else if (stall_left == 0 && out_tready && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 10);
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_small_values();
    for (int i = 0; i < 8; i++) send_value(64'(i));
    send_value(64'd63);
    send_value(64'd64);
    send_value(64'd127);
  endtask

  task automatic test_extremes();
    send_value('1);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h5555_5555_5555_5555);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'd1000000);
    send_value(64'h0000_0000_FFFF_FFFF);
    send_value(64'h0000_0001_0000_0000);
    idle_input();
    drain();
  endtask

  task automatic test_random(input int count);
    logic [63:0] v;
    int w;
    for (int i = 0; i < count; i++) begin
      if (i == count * 3 / 4) calm = 1'b1;
      v = {$urandom, $urandom};
      w = $urandom_range(1, 64);
      if ($urandom_range(0, 3) != 0) v = v >> (64 - w);
      send_value(v);
    end
    idle_input();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_values();
    test_extremes();
    test_random(400);
    drain();
    repeat (80) @(posedge clk);
    $display("Covered %0d operands: small table range, bit-width extremes, random widths,",
             sent);
    $display("with random stalls on both sides; %0d roots checked.", checked);
    if (errors == 0 && roots_due.size() == 0) begin
      $display("integer_cube_root_unit_test passed");
    end else begin
      $display("integer_cube_root_unit_test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("integer_cube_root_unit_test failed");
    $finish;
  end

endmodule

@@ integer_cube_root_unit.f @@
rtl/core/icr_pkg.sv
rtl/core/icr_seed.sv
rtl/core/icr_div_cell.sv
rtl/core/integer_cube_root_unit.sv
verif/integer_cube_root_unit_test.sv
